[design/ptdm_pkg.sv]
// Shared types, event codes and constants for the periodic task deadline monitor.
package ptdm_pkg;

   localparam int TimeWidth   = 31;
   localparam int StampWidth  = 32;
   localparam int CountWidth  = 32;
   localparam int PeriodWidth = 16;
   localparam int FuncWidth   = 3;

   localparam logic [StampWidth-1:0] TIME_NONE = '1;
   localparam logic [StampWidth-1:0] TIME_MAX  = {1'b0, {(StampWidth-1){1'b1}}};

   typedef enum logic [FuncWidth-1:0] {
      FUNC_RELEASE  = 3'd0,
      FUNC_ADMIT    = 3'd1,
      FUNC_CANCEL   = 3'd2,
      FUNC_START    = 3'd3,
      FUNC_COMPLETE = 3'd4,
      FUNC_OBSERVE  = 3'd5
   } func_type;

   typedef logic [TimeWidth-1:0]   time_type;
   typedef logic [StampWidth-1:0]  stamp_type;
   typedef logic [CountWidth-1:0]  count_type;
   typedef logic [PeriodWidth-1:0] period_type;

   // Input word, lowest bit first: now, drop_outstanding.
   typedef struct packed {
      logic     drop_outstanding;
      time_type now;
   } req_word_type;

   // Result word, lowest bit first: sample_time, release_count,
   // completion_count, cancel_count, missed_flag, deadline_flag,
   // outstanding_flag, age_since_success, job_release_time, start_time,
   // finish_time, zero pad.
   typedef struct packed {
      logic [5:0] pad;
      stamp_type  finish_time;
      stamp_type  start_time;
      stamp_type  job_release_time;
      count_type  age_since_success;
      logic       outstanding_flag;
      logic       deadline_flag;
      logic       missed_flag;
      count_type  cancel_count;
      count_type  completion_count;
      count_type  release_count;
      time_type   sample_time;
   } rsp_word_type;

endpackage

[design/ptdm_state_unit.sv]
// Task state registers, period register and the per-event update logic.
module ptdm_state_unit import ptdm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  period_type   csr_wr_data,
   input  logic         upd,
   input  func_type     func,
   input  req_word_type word,
   output rsp_word_type rsp_in
);

   period_type period_ff;
   stamp_type  latest_ff, latest_in;
   stamp_type  admitted_ff, admitted_in;
   stamp_type  start_ff, start_in;
   stamp_type  finish_ff, finish_in;
   stamp_type  success_ff, success_in;
   stamp_type  pending_ff, pending_in;
   count_type  releases_ff, releases_in;
   count_type  completions_ff, completions_in;
   count_type  cancels_ff, cancels_in;
   time_type   sample_ff, sample_in;
   count_type  age_ff, age_in;
   logic       missed_ff, missed_in;
   logic       deadline_ff, deadline_in;
   logic       outstanding_ff, outstanding_in;

   stamp_type now_ext;
   stamp_type cancel_sum;
   stamp_type admit_deadline;

   assign now_ext        = {1'b0, word.now};
   assign cancel_sum     = latest_ff + {{(StampWidth-PeriodWidth){1'b0}}, period_ff};
   assign admit_deadline = admitted_ff + {{(StampWidth-PeriodWidth){1'b0}}, period_ff};

   always_comb begin
      latest_in      = latest_ff;
      admitted_in    = admitted_ff;
      start_in       = start_ff;
      finish_in      = finish_ff;
      success_in     = success_ff;
      pending_in     = pending_ff;
      releases_in    = releases_ff;
      completions_in = completions_ff;
      cancels_in     = cancels_ff;
      sample_in      = sample_ff;
      age_in         = age_ff;
      missed_in      = missed_ff;
      deadline_in    = deadline_ff;
      outstanding_in = outstanding_ff;
      if (period_ff != '0) begin
         unique case (func)
            FUNC_RELEASE: begin
               sample_in   = word.now;
               latest_in   = now_ext;
               releases_in = releases_ff + 1'b1;
               missed_in   = 1'b0;
               deadline_in = !pending_ff[StampWidth-1] && (now_ext >= pending_ff);
               if (deadline_in) begin
                  pending_in = TIME_NONE;
               end
            end
            FUNC_ADMIT: begin
               outstanding_in = 1'b1;
               admitted_in    = latest_ff;
               start_in       = TIME_NONE;
               finish_in      = TIME_NONE;
            end
            FUNC_CANCEL: begin
               missed_in  = 1'b1;
               cancels_in = cancels_ff + 1'b1;
               pending_in = cancel_sum[StampWidth-1] ? TIME_MAX : cancel_sum;
               if (word.drop_outstanding) begin
                  outstanding_in = 1'b0;
               end
            end
            FUNC_START: begin
               start_in = now_ext;
            end
            FUNC_COMPLETE: begin
               finish_in      = now_ext;
               success_in     = now_ext;
               completions_in = completions_ff + 1'b1;
               outstanding_in = 1'b0;
            end
            FUNC_OBSERVE: begin
               sample_in = word.now;
               age_in    = success_ff[StampWidth-1] ? now_ext : now_ext - success_ff;
               if (!admitted_ff[StampWidth-1]) begin
                  if ((outstanding_ff && now_ext >= admit_deadline) ||
                      (finish_ff == now_ext && now_ext > admit_deadline)) begin
                     deadline_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in                   = '0;
      rsp_in.sample_time       = sample_in;
      rsp_in.release_count     = releases_in;
      rsp_in.completion_count  = completions_in;
      rsp_in.cancel_count      = cancels_in;
      rsp_in.missed_flag       = missed_in;
      rsp_in.deadline_flag     = deadline_in;
      rsp_in.outstanding_flag  = outstanding_in;
      rsp_in.age_since_success = age_in;
      rsp_in.job_release_time  = admitted_in;
      rsp_in.start_time        = start_in;
      rsp_in.finish_time       = finish_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else if (csr_wr_en) begin
         period_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latest_ff      <= TIME_NONE;
         admitted_ff    <= TIME_NONE;
         start_ff       <= TIME_NONE;
         finish_ff      <= TIME_NONE;
         success_ff     <= TIME_NONE;
         pending_ff     <= TIME_NONE;
         releases_ff    <= '0;
         completions_ff <= '0;
         cancels_ff     <= '0;
         sample_ff      <= '0;
         age_ff         <= '0;
         missed_ff      <= 1'b0;
         deadline_ff    <= 1'b0;
         outstanding_ff <= 1'b0;
      end else if (upd) begin
         latest_ff      <= latest_in;
         admitted_ff    <= admitted_in;
         start_ff       <= start_in;
         finish_ff      <= finish_in;
         success_ff     <= success_in;
         pending_ff     <= pending_in;
         releases_ff    <= releases_in;
         completions_ff <= completions_in;
         cancels_ff     <= cancels_in;
         sample_ff      <= sample_in;
         age_ff         <= age_in;
         missed_ff      <= missed_in;
         deadline_ff    <= deadline_in;
         outstanding_ff <= outstanding_in;
      end
   end

`ifndef SYNTHESIS
   a_release_bumps_count: assert property (@(posedge clock) disable iff (reset)
      (upd && period_ff != '0 && func == FUNC_RELEASE) |=>
         releases_ff == $past(releases_ff) + 1'b1)
      else $error("release count did not advance on release");

   a_disabled_holds: assert property (@(posedge clock) disable iff (reset)
      (upd && period_ff == '0) |=>
         $stable(releases_ff) && $stable(cancels_ff) && $stable(deadline_ff))
      else $error("state changed while monitor disabled");

   a_pending_saturates: assert property (@(posedge clock) disable iff (reset)
      (upd && period_ff != '0 && func == FUNC_CANCEL) |=> !pending_ff[StampWidth-1])
      else $error("pending deadline left range on cancel");
`endif

endmodule

[design/periodic_task_deadline_monitor.sv]
// Top level: input word register, task state unit and result word register.
// Throughput: one word per cycle unless a held result word waits for rsp_tready.
// Input register frees as its word moves into the result register; the state
// updates in that same cycle, so consecutive events see each other's effect.
// Reset: synchronous, active high; period zero, times none, counts and flags clear.
module periodic_task_deadline_monitor import ptdm_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [PeriodWidth-1:0]    csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [31:0]               req_tdata,   // now, drop_outstanding
   input  logic [FuncWidth-1:0]      req_tuser,   // func
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [263:0]              rsp_tdata    // sample_time, release_count,
                                                  // completion_count, cancel_count,
                                                  // missed_flag, deadline_flag,
                                                  // outstanding_flag, age_since_success,
                                                  // job_release_time, start_time,
                                                  // finish_time, zero pad
);

   logic         in_valid_ff;
   req_word_type word_ff;
   func_type     func_ff;
   logic         out_valid_ff;
   rsp_word_type result_ff;
   rsp_word_type result_in;
   logic         advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result_ff;

   ptdm_state_unit u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .upd         (advance),
      .func        (func_ff),
      .word        (word_ff),
      .rsp_in      (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         word_ff <= req_tdata;
         func_ff <= func_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

`ifndef SYNTHESIS
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result word lost after advance");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> result_ff.pad == '0)
      else $error("result pad bits not zero");
`endif

endmodule
